[src/tsm_pkg.sv]
// shared types and constants for the temporal sparsity meter
package tsm_pkg;

	localparam int MaxWindowDef = 128;
	localparam int MaxBlockDef  = 4096;
	localparam int SampleBitsDef = 16;

	localparam int WinSizeW = 8;
	localparam int BlkSizeW = 13;
	localparam int OutW     = 17;
	localparam int RmsW     = 16;

	localparam logic [7:0]  WinSizeReset = 8'd50;
	localparam logic [12:0] BlkSizeReset = 13'd1024;

	typedef enum logic {
		REG_WINDOW_SIZE = 1'b0,
		REG_BLOCK_SIZE  = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_ACCUM,
		ST_DIV,
		ST_SQRT,
		ST_WRITE,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_MUL,
		ST_QUOT,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic div_start;
		logic div_step;
		logic sqrt_start;
		logic sqrt_step;
		logic win_write;
		logic scan_start;
		logic scan_step;
		logic mul_load;
		logic quot_start;
		logic quot_step;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic block_end;
		logic div_done;
		logic sqrt_done;
		logic scan_last;
		logic quot_done;
	} status_t;

endpackage

[src/tsm_ram.sv]
// generic single-port-write ram with registered read
module tsm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/tsm_ctrl.sv]
// controller state machine for the sparsity meter
module tsm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  tsm_pkg::status_t    st,
	output tsm_pkg::cmd_t       cmd
);
	tsm_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic acc_ok;

	// a sample may enter while the previous result still waits
	assign acc_ok   = (state_q == tsm_pkg::ST_ACCUM);
	assign in_ready = acc_ok;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsm_pkg::ST_ACCUM: if (in_valid && st.block_end) state_d = tsm_pkg::ST_DIV;
			tsm_pkg::ST_DIV: if (st.div_done) state_d = tsm_pkg::ST_SQRT;
			tsm_pkg::ST_SQRT: if (st.sqrt_done) state_d = tsm_pkg::ST_WRITE;
			tsm_pkg::ST_WRITE: state_d = tsm_pkg::ST_SCAN;
			tsm_pkg::ST_SCAN: if (st.scan_last) state_d = tsm_pkg::ST_SCAN_LAST;
			tsm_pkg::ST_SCAN_LAST: state_d = tsm_pkg::ST_MUL;
			tsm_pkg::ST_MUL: state_d = tsm_pkg::ST_QUOT;
			tsm_pkg::ST_QUOT: if (st.quot_done) state_d = tsm_pkg::ST_OUT;
			tsm_pkg::ST_OUT: if (!out_valid_q || out_ready) state_d = tsm_pkg::ST_ACCUM;
			default: state_d = tsm_pkg::ST_ACCUM;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			tsm_pkg::ST_ACCUM: begin
				cmd.accept    = in_valid;
				cmd.div_start = in_valid && st.block_end;
			end
			tsm_pkg::ST_DIV: begin
				cmd.div_step   = 1'b1;
				cmd.sqrt_start = st.div_done;
			end
			tsm_pkg::ST_SQRT: cmd.sqrt_step = 1'b1;
			tsm_pkg::ST_WRITE: begin
				cmd.win_write  = 1'b1;
				cmd.scan_start = 1'b1;
			end
			tsm_pkg::ST_SCAN: cmd.scan_step = 1'b1;
			// last read data lands here, no further address
			tsm_pkg::ST_SCAN_LAST: cmd = '0;
			tsm_pkg::ST_MUL: begin
				cmd.mul_load   = 1'b1;
				cmd.quot_start = 1'b1;
			end
			tsm_pkg::ST_QUOT: cmd.quot_step = 1'b1;
			tsm_pkg::ST_OUT: cmd.out_load = !out_valid_q || out_ready;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tsm_pkg::ST_ACCUM;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

[src/tsm_dp.sv]
// datapath: accumulator, divider, square root, window scan and ratio
module tsm_dp #(
	parameter int MAX_WINDOW  = tsm_pkg::MaxWindowDef,
	parameter int MAX_BLOCK   = tsm_pkg::MaxBlockDef,
	parameter int SAMPLE_BITS = tsm_pkg::SampleBitsDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                         cfg_win,
	input  logic                         cfg_blk,
	input  logic [tsm_pkg::WinSizeW-1:0] window_size_q,
	input  logic [tsm_pkg::BlkSizeW-1:0] block_size_q,
	input  tsm_pkg::cmd_t                cmd,
	output tsm_pkg::status_t             st,
	output logic [tsm_pkg::OutW-1:0]     sparsity
);
	localparam int WIDX = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int FILLW = $clog2(MAX_WINDOW + 1);
	localparam int BLKW = $clog2(MAX_BLOCK + 1);
	localparam int SQW = 2 * SAMPLE_BITS;
	localparam int ACCW = SQW + BLKW;
	localparam int SXW = ACCW + (ACCW % 2);
	localparam int RW = tsm_pkg::RmsW;
	localparam int SUMW = RW + FILLW;
	localparam int NUMW = FILLW + RW + 16;
	localparam int DENW = FILLW + SUMW;
	localparam int CNTW = $clog2(ACCW + 1);
	localparam int ROOTW = (ACCW + 1) / 2;
	localparam int QW = tsm_pkg::OutW;

	// effective sizes
	logic [FILLW-1:0] w_eff;
	logic [BLKW-1:0]  n_eff;
	always_comb begin
		if (window_size_q == '0) w_eff = FILLW'(1);
		else if (32'(window_size_q) > MAX_WINDOW) w_eff = FILLW'(MAX_WINDOW);
		else w_eff = FILLW'(window_size_q);
		if (block_size_q == '0) n_eff = BLKW'(1);
		else if (32'(block_size_q) > MAX_BLOCK) n_eff = BLKW'(MAX_BLOCK);
		else n_eff = BLKW'(block_size_q);
	end

	// accumulate
	logic [ACCW-1:0] acc_q;
	logic [BLKW-1:0] cnt_q;
	logic [SAMPLE_BITS-1:0] mag;
	logic [SQW-1:0] sq;
	logic [ACCW-1:0] acc_next;
	assign mag = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
	assign sq = SQW'(mag) * SQW'(mag);
	assign acc_next = acc_q + ACCW'(sq);
	assign st.block_end = (cnt_q + BLKW'(1)) >= n_eff;

	// restoring divider, one bit a cycle
	logic [ACCW-1:0] dq_q, drem_q;
	logic [CNTW-1:0] dcnt_q;
	logic [ACCW:0]   dtrial;
	logic [ACCW-1:0] dquo;
	assign dtrial = {drem_q, dq_q[ACCW-1]} - (ACCW+1)'(n_eff);
	assign st.div_done = (dcnt_q == CNTW'(1));
	// full quotient including the bit decided in the last step
	assign dquo = {dq_q[ACCW-2:0], !dtrial[ACCW]};

	// bit-pair square root, one root bit a cycle
	logic [SXW-1:0]   sx_q;
	logic [ROOTW+1:0] srem_q;
	logic [ROOTW-1:0] root_q;
	logic [CNTW-1:0]  scnt_q;
	logic [ROOTW+1:0] srem_sh, strial;
	assign srem_sh = {srem_q[ROOTW-1:0], sx_q[SXW-1 -: 2]};
	assign strial = srem_sh - {root_q, 2'b01};
	assign st.sqrt_done = (scnt_q == CNTW'(1));

	// window
	logic [WIDX-1:0]  widx_q;
	logic [FILLW-1:0] fill_q;
	logic [RW-1:0]    rms_val;
	logic [WIDX-1:0]  raddr_q;
	logic [FILLW-1:0] rcnt_q;
	logic             rvalid_q;
	logic [RW-1:0]    rdata;
	logic [RW-1:0]    max_q;
	logic [SUMW-1:0]  sum_q;
	logic [WIDX-1:0]  wpos;
	assign wpos = (FILLW'(widx_q) >= w_eff) ? '0 : widx_q;
	assign rms_val = (root_q > ROOTW'(16'hFFFF)) ? 16'hFFFF : RW'(root_q);
	assign st.scan_last = (rcnt_q <= FILLW'(1));

	tsm_ram #(.WIDTH(RW), .DEPTH(MAX_WINDOW)) u_ram (
		.clk(clk), .we(cmd.win_write), .waddr(wpos), .wdata(rms_val),
		.raddr(raddr_q), .rdata(rdata)
	);

	// ratio: numerator and denominator, then long division
	logic [NUMW-1:0] qn_q;
	logic [DENW-1:0] den_q;
	logic [DENW:0]   qrem_q;
	logic [DENW+1:0] qtrial;
	logic [QW-1:0]   quo_q;
	logic [$clog2(NUMW+1)-1:0] qcnt_q;
	logic            zero_q;
	logic [QW-1:0]   res;
	assign qtrial = {qrem_q, qn_q[NUMW-1]} - (DENW+2)'(den_q);
	assign st.quot_done = (qcnt_q == ($clog2(NUMW+1))'(1));
	assign res = zero_q ? '0 : ((quo_q > QW'(65536)) ? QW'(65536) : quo_q);

	logic [FILLW-1:0] fill_new;
	assign fill_new = (fill_q < w_eff) ? fill_q + FILLW'(1) : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			cnt_q  <= '0;
			widx_q <= '0;
			fill_q <= '0;
			dcnt_q <= '0;
			scnt_q <= '0;
			qcnt_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (cfg_blk) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else if (cmd.accept) begin
				if (st.block_end) begin
					acc_q <= '0;
					cnt_q <= '0;
				end else begin
					acc_q <= acc_next;
					cnt_q <= cnt_q + BLKW'(1);
				end
			end
			if (cfg_win) begin
				widx_q <= '0;
				fill_q <= '0;
			end else if (cmd.win_write) begin
				widx_q <= (FILLW'(wpos) + FILLW'(1) >= w_eff) ? '0 : wpos + WIDX'(1);
				fill_q <= fill_new;
			end
			if (cmd.div_start) dcnt_q <= CNTW'(ACCW);
			else if (cmd.div_step && dcnt_q != '0) dcnt_q <= dcnt_q - CNTW'(1);
			if (cmd.sqrt_start) scnt_q <= CNTW'(ROOTW);
			else if (cmd.sqrt_step && scnt_q != '0) scnt_q <= scnt_q - CNTW'(1);
			if (cmd.quot_start) qcnt_q <= ($clog2(NUMW+1))'(NUMW);
			else if (cmd.quot_step && qcnt_q != '0) qcnt_q <= qcnt_q - ($clog2(NUMW+1))'(1);
			rvalid_q <= cmd.scan_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dq_q   <= acc_next;
			drem_q <= '0;
		end else if (cmd.div_step) begin
			if (!dtrial[ACCW]) begin
				drem_q <= dtrial[ACCW-1:0];
				dq_q   <= {dq_q[ACCW-2:0], 1'b1};
			end else begin
				drem_q <= {drem_q[ACCW-2:0], dq_q[ACCW-1]};
				dq_q   <= {dq_q[ACCW-2:0], 1'b0};
			end
		end
		if (cmd.sqrt_start) begin
			sx_q   <= SXW'(dquo);
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			sx_q <= {sx_q[SXW-3:0], 2'b00};
			if (!strial[ROOTW+1]) begin
				srem_q <= strial;
				root_q <= {root_q[ROOTW-2:0], 1'b1};
			end else begin
				srem_q <= srem_sh;
				root_q <= {root_q[ROOTW-2:0], 1'b0};
			end
		end
		if (cmd.scan_start) begin
			raddr_q <= '0;
			rcnt_q  <= fill_new;
			max_q   <= '0;
			sum_q   <= '0;
		end else if (cmd.scan_step) begin
			raddr_q <= raddr_q + WIDX'(1);
			rcnt_q  <= rcnt_q - FILLW'(1);
		end
		if (rvalid_q) begin
			if (rdata > max_q) max_q <= rdata;
			sum_q <= sum_q + SUMW'(rdata);
		end
		if (cmd.mul_load) begin
			den_q  <= DENW'(w_eff) * DENW'(sum_q);
			zero_q <= (sum_q == '0);
		end
		if (cmd.quot_start) begin
			qn_q   <= NUMW'(fill_q) * NUMW'(max_q) << 16;
			qrem_q <= '0;
			quo_q  <= '0;
		end else if (cmd.quot_step) begin
			qn_q <= {qn_q[NUMW-2:0], 1'b0};
			if (!qtrial[DENW+1]) begin
				qrem_q <= qtrial[DENW:0];
				quo_q  <= (quo_q > QW'(65536)) ? quo_q : {quo_q[QW-2:0], 1'b1};
			end else begin
				qrem_q <= {qrem_q[DENW-1:0], qn_q[NUMW-1]};
				quo_q  <= (quo_q > QW'(65536)) ? quo_q : {quo_q[QW-2:0], 1'b0};
			end
		end
		if (cmd.out_load) sparsity <= res;
	end
endmodule

[src/temporal_sparsity_meter.sv]
// top level of the temporal sparsity meter
// block end: the result follows the divider steps, the square-root steps, the window
// write and the read of every filled entry, and the ratio steps, all set by the
// one-bit-per-cycle divider, root and window memory port
// throughput: one sample per cycle inside a block, one block result at a time
// reset: accumulator, counts and window fill clear; window memory is not cleared
module temporal_sparsity_meter #(
	parameter int MAX_WINDOW  = tsm_pkg::MaxWindowDef,
	parameter int MAX_BLOCK   = tsm_pkg::MaxBlockDef,
	parameter int SAMPLE_BITS = tsm_pkg::SampleBitsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tsm_pkg::OutW-1:0]      sparsity,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [tsm_pkg::BlkSizeW-1:0]  cfg_data
);
	tsm_pkg::cmd_t    cmd;
	tsm_pkg::status_t st;
	logic [tsm_pkg::WinSizeW-1:0] window_size_q;
	logic [tsm_pkg::BlkSizeW-1:0] block_size_q;
	logic cfg_win, cfg_blk;

	assign cfg_ready = 1'b1;
	assign cfg_win = cfg_valid && (cfg_index == tsm_pkg::REG_WINDOW_SIZE);
	assign cfg_blk = cfg_valid && (cfg_index == tsm_pkg::REG_BLOCK_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= tsm_pkg::WinSizeReset;
			block_size_q  <= tsm_pkg::BlkSizeReset;
		end else begin
			if (cfg_win) window_size_q <= cfg_data[tsm_pkg::WinSizeW-1:0];
			if (cfg_blk) block_size_q <= cfg_data;
		end
	end

	tsm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .st(st), .cmd(cmd)
	);

	tsm_dp #(.MAX_WINDOW(MAX_WINDOW), .MAX_BLOCK(MAX_BLOCK), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .sample(sample), .cfg_win(cfg_win), .cfg_blk(cfg_blk),
		.window_size_q(window_size_q), .block_size_q(block_size_q), .cmd(cmd), .st(st),
		.sparsity(sparsity)
	);

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sparsity <= 17'd65536) else $error("sparsity above one");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !in_ready) else $error("sample taken during block work");
endmodule

[dv/tsm_checker.sv]
// request monitor, sparsity predictor and result comparison for the meter
`timescale 1ns / 100ps

module tsm_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic signed [15:0]           sample,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [tsm_pkg::OutW-1:0]     sparsity,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [tsm_pkg::BlkSizeW-1:0] cfg_data,
	output int                           errors,
	output int                           pending
);
	logic [7:0]                 win_reg;
	logic [12:0]                blk_reg;
	longint unsigned            sq_sum;
	longint unsigned            blk_count;
	logic [15:0]                rms_ring [128];
	longint unsigned            ring_wr;
	longint unsigned            ring_fill;
	logic [tsm_pkg::OutW-1:0]   sparsity_q [$];

	function automatic longint unsigned root_floor(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// one accepted sample; queues a sparsity value at each block end
	task automatic take_sample(input logic signed [15:0] s);
		logic signed [16:0] wide;
		longint unsigned    mag;
		longint unsigned    n;
		longint unsigned    w;
		longint unsigned    rms;
		longint unsigned    peak;
		longint unsigned    total;
		longint unsigned    res;
		wide = s;
		mag = (wide < 0) ? longint'(-wide) : longint'(wide);
		n = (blk_reg == 0) ? 1 : (blk_reg > 4096) ? 4096 : blk_reg;
		w = (win_reg == 0) ? 1 : (win_reg > 128) ? 128 : win_reg;
		sq_sum += mag * mag;
		blk_count++;
		if (blk_count < n) return;
		rms = root_floor(sq_sum / n);
		if (rms > 64'hFFFF) rms = 64'hFFFF;
		sq_sum = 0;
		blk_count = 0;
		if (ring_wr >= w) ring_wr = 0;
		rms_ring[ring_wr] = rms[15:0];
		ring_wr++;
		if (ring_wr >= w) ring_wr = 0;
		if (ring_fill < w) ring_fill++;
		peak = 0;
		total = 0;
		for (int i = 0; i < ring_fill; i++) begin
			if (rms_ring[i] > peak) peak = rms_ring[i];
			total += rms_ring[i];
		end
		if (total == 0) begin
			res = 0;
		end else begin
			res = (ring_fill * peak * 65536) / (w * total);
			if (res > 65536) res = 65536;
		end
		sparsity_q.insert(sparsity_q.size(), res[tsm_pkg::OutW-1:0]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_reg = tsm_pkg::WinSizeReset;
			blk_reg = tsm_pkg::BlkSizeReset;
			sq_sum = 0;
			blk_count = 0;
			ring_wr = 0;
			ring_fill = 0;
			sparsity_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (sparsity_q.size() == 0) begin
					$display("%0t: unexpected sparsity result, actual %0d", $time, sparsity);
					errors++;
				end else begin
					if (sparsity !== sparsity_q[0]) begin
						$display("%0t: sparsity mismatch, expected %0d, actual %0d",
							$time, sparsity_q[0], sparsity);
						errors++;
					end
					void'(sparsity_q.pop_front());
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == tsm_pkg::REG_WINDOW_SIZE) begin
					win_reg = cfg_data[7:0];
					ring_wr = 0;
					ring_fill = 0;
				end else begin
					blk_reg = cfg_data;
					sq_sum = 0;
					blk_count = 0;
				end
			end
			if (in_valid && in_ready) take_sample(sample);
			pending = sparsity_q.size();
		end
	end
endmodule

[dv/temporal_sparsity_meter_test.sv]
// stimulus, configuration phases and verdict for the temporal sparsity meter
`timescale 1ns / 100ps

module temporal_sparsity_meter_test;
	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic signed [15:0]           sample;
	logic                         out_valid;
	logic                         out_ready;
	logic [tsm_pkg::OutW-1:0]     sparsity;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic                         cfg_index;
	logic [tsm_pkg::BlkSizeW-1:0] cfg_data;
	int                           errors;
	int                           pending;
	logic                         in_took;
	logic                         cfg_took;
	logic                         calm;
	logic                         hold_go;
	int                           hold_left;
	int                           quiet;

	temporal_sparsity_meter u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready), .sparsity(sparsity),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tsm_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready), .sparsity(sparsity),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		in_took <= in_valid && in_ready;
		cfg_took <= cfg_valid && cfg_ready;
	end

	// receiver, with one long hold-off so the block backs up
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready = 1'b0;
		end else if (hold_go) begin
			hold_go = 1'b0;
			hold_left = 1500;
			out_ready = 1'b0;
		end else begin
			out_ready = calm ? 1'b1 : ($urandom_range(0, 99) >= 34);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= 20000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic push_sample(input logic signed [15:0] s);
		while (!calm && $urandom_range(0, 99) < 34) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		sample = s;
		do @(negedge clk); while (!in_took);
		in_valid = 1'b0;
	endtask

	task automatic write_reg(input tsm_pkg::reg_idx_t idx,
		input logic [tsm_pkg::BlkSizeW-1:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(negedge clk); while (!cfg_took);
		cfg_valid = 1'b0;
	endtask

	// drain every expected result, then let the back end settle
	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	function automatic logic signed [15:0] pick_sample(input int mode);
		case (mode)
			0: return 16'($urandom);
			1: return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'sd0;
			default: return ($urandom_range(0, 1) == 0) ? 16'sh8000 : 16'sd0;
		endcase
	endfunction

	logic signed [15:0] edge_vals [20] = '{
		16'sd0, 16'sd0, 16'sd32767, 16'sh8000, -16'sd1, 16'sd1, 16'sd0, 16'sd16384,
		-16'sd16384, 16'sd255, -16'sd256, 16'h5555, 16'hAAAA, 16'sd0, 16'sd0, 16'sd0,
		16'sd0, 16'sd100, -16'sd50, 16'sd32767};

	initial begin
		int mode;
		int ws;
		int bs;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		cfg_valid = 1'b0;
		cfg_index = tsm_pkg::REG_WINDOW_SIZE;
		cfg_data = '0;
		calm = 1'b0;
		hold_go = 1'b0;
		hold_left = 0;
		quiet = 0;
		out_ready = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// all-zero opening gives a zero sum, then the field extremes
		write_reg(tsm_pkg::REG_WINDOW_SIZE, 13'd4);
		write_reg(tsm_pkg::REG_BLOCK_SIZE, 13'd1);
		foreach (edge_vals[i]) push_sample(edge_vals[i]);
		drain();

		// zero sizes act as one; upper data bits of the window write are dropped
		write_reg(tsm_pkg::REG_WINDOW_SIZE, 13'h1F00);
		write_reg(tsm_pkg::REG_BLOCK_SIZE, 13'd0);
		repeat (20) push_sample(pick_sample(0));
		drain();

		// oversize registers clamp to the largest window and block
		write_reg(tsm_pkg::REG_WINDOW_SIZE, 13'd255);
		write_reg(tsm_pkg::REG_BLOCK_SIZE, 13'd8191);
		repeat (60) push_sample(pick_sample(0));
		drain();

		// the largest window fills and wraps past its last entry
		write_reg(tsm_pkg::REG_BLOCK_SIZE, 13'd1);
		repeat (140) push_sample(pick_sample(1));
		drain();

		for (int ph = 0; ph < 22; ph++) begin
			case ($urandom_range(0, 5))
				0: ws = 1;
				1: ws = 2;
				2: ws = 128;
				3: ws = 129 + $urandom_range(0, 126);
				default: ws = $urandom_range(1, 128);
			endcase
			bs = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 8);
			if (ph == 4) bs = 1;
			case ($urandom_range(0, 3))
				0: write_reg(tsm_pkg::REG_WINDOW_SIZE, {5'($urandom), 8'(ws)});
				1: write_reg(tsm_pkg::REG_BLOCK_SIZE, 13'(bs));
				default: begin
					write_reg(tsm_pkg::REG_WINDOW_SIZE, {5'($urandom), 8'(ws)});
					write_reg(tsm_pkg::REG_BLOCK_SIZE, 13'(bs));
				end
			endcase
			// one result per sample while the receiver holds off
			if (ph == 4) write_reg(tsm_pkg::REG_BLOCK_SIZE, 13'(bs));
			calm = (ph == 7);
			hold_go = (ph == 4);
			mode = $urandom_range(0, 2);
			repeat (45) push_sample(pick_sample(mode));
			calm = 1'b0;
			drain();
		end

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

[filelist.f]
src/tsm_pkg.sv
src/tsm_ram.sv
src/tsm_ctrl.sv
src/tsm_dp.sv
src/temporal_sparsity_meter.sv
dv/tsm_checker.sv
dv/temporal_sparsity_meter_test.sv
